// ----- design/joystick_expo_curve_core_macros.svh -----
// assertion macros for the joystick expo curve core
// included by the top level, no other dependencies
`ifndef JOYSTICK_EXPO_CURVE_CORE_MACROS_SVH
`define JOYSTICK_EXPO_CURVE_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define JEC_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("jec: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define JEC_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("jec: next-cycle check failed");

`endif

// ----- design/jec_pkg.sv -----
// shared types, constants and helpers for the joystick expo curve core
// no dependencies
package jec_pkg;

  localparam int RECIP_W   = 17;
  localparam int MAG_W     = 7;
  localparam int STICK_W   = 8;
  localparam int K_W       = 14;
  localparam int DSH_W     = 13;
  localparam int POW_STEPS = 7;
  localparam int DIV_STEPS = 7;

  localparam logic [RECIP_W-1:0] RECIP_MIN = 17'd50412;
  localparam logic [RECIP_W-1:0] RECIP_ONE = 17'd65536;
  localparam logic [STICK_W-1:0] STICK_MAX = 8'd127;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_BASE_RECIP = 2'd0,
    REG_FULL_SCALE = 2'd1,
    REG_DEADBAND   = 2'd2,
    REG_MIN_OUTPUT = 2'd3
  } jec_reg_t;

  typedef struct packed {
    logic [RECIP_W-1:0] base_recip;
    logic [MAG_W-1:0]   full_scale;
    logic [MAG_W-1:0]   deadband;
    logic [MAG_W-1:0]   min_output;
  } jec_cfg_t;

  // one sample as it travels down the pipe
  typedef struct packed {
    logic               neg;    // reading was negative
    logic               zero;   // inside deadband or zero reading
    logic               flat;   // deadband equals full scale
    logic [MAG_W-1:0]   n;      // clamped min_output
    logic [MAG_W-1:0]   den;    // full scale minus deadband
    logic [MAG_W-1:0]   e;      // remaining exponent bits
    logic [RECIP_W-1:0] acc;    // power accumulator, q1.16
    logic [RECIP_W-1:0] sq;     // running square, q1.16
    logic [K_W-1:0]     k;      // (s - n) * (m - d)
    logic [DSH_W-1:0]   dsh;    // shifted divisor for the current quotient bit
    logic [K_W-1:0]     rem;    // division remainder
    logic [MAG_W-1:0]   quo;    // quotient bits so far
  } jec_item_t;

  // q1.16 product, truncated
  function automatic logic [RECIP_W-1:0] q16_mul(input logic [RECIP_W-1:0] a,
                                                 input logic [RECIP_W-1:0] b);
    logic [2*RECIP_W-1:0] p;
    p = {{RECIP_W{1'b0}}, a} * {{RECIP_W{1'b0}}, b};
    return p[RECIP_W+15:16];
  endfunction

endpackage

// ----- design/jec_front.sv -----
// input stage: magnitude, clamping of settings, deadband test, span product
// depends on jec_pkg
module jec_front import jec_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  input  logic signed [STICK_W-1:0] stick_value,
  input  jec_cfg_t                  cfg,
  input  logic                      dn_ready,
  output logic                      up_ready,
  output logic                      dn_valid,
  output jec_item_t                 dn_item
);

  logic             valid_r;
  jec_item_t        item_r;
  jec_item_t        item_nxt;
  logic [STICK_W-1:0] raw;
  logic [STICK_W-1:0] mag;
  logic [MAG_W-1:0] s;
  logic [MAG_W-1:0] d;
  logic [MAG_W-1:0] n;
  logic [MAG_W-1:0] m;
  logic [MAG_W-1:0] span_n;
  logic [MAG_W-1:0] span_m;
  logic [RECIP_W-1:0] b;

  // settings clamped to their working ranges
  always_comb begin
    s = (cfg.full_scale == '0) ? MAG_W'(1) : cfg.full_scale;
    d = (cfg.deadband > s) ? s : cfg.deadband;
    n = (cfg.min_output > s) ? s : cfg.min_output;
    if (cfg.base_recip < RECIP_MIN) begin
      b = RECIP_MIN;
    end else if (cfg.base_recip > RECIP_ONE) begin
      b = RECIP_ONE;
    end else begin
      b = cfg.base_recip;
    end
  end

  // magnitude, saturation and span product
  always_comb begin
    raw = $unsigned(stick_value);
    mag = raw[STICK_W-1] ? (STICK_W'(0) - raw) : raw;
    m = (mag > {1'b0, s}) ? s : mag[MAG_W-1:0];
    span_n = s - n;
    span_m = m - d;
    item_nxt = '0;
    item_nxt.neg  = raw[STICK_W-1];
    item_nxt.zero = (mag == '0) || (mag < {1'b0, d});
    item_nxt.flat = (s == d);
    item_nxt.n    = n;
    item_nxt.den  = s - d;
    item_nxt.e    = s - m;
    item_nxt.acc  = RECIP_ONE;
    item_nxt.sq   = b;
    item_nxt.k    = {{(K_W-MAG_W){1'b0}}, span_n} * {{(K_W-MAG_W){1'b0}}, span_m};
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

// ----- design/jec_pow_stage.sv -----
// one exponent bit of the square-and-multiply power, lsb first
// depends on jec_pkg
module jec_pow_stage import jec_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  input  jec_item_t up_item,
  input  logic      dn_ready,
  output logic      up_ready,
  output logic      dn_valid,
  output jec_item_t dn_item
);

  logic      valid_r;
  jec_item_t item_r;
  jec_item_t item_nxt;

  // multiply in the square where the bit is set, then square
  always_comb begin
    item_nxt     = up_item;
    item_nxt.acc = up_item.e[0] ? q16_mul(up_item.acc, up_item.sq) : up_item.acc;
    item_nxt.sq  = q16_mul(up_item.sq, up_item.sq);
    item_nxt.e   = up_item.e >> 1;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

// ----- design/jec_div_stage.sv -----
// one restoring division step, one quotient bit msb first
// depends on jec_pkg
module jec_div_stage import jec_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  input  jec_item_t up_item,
  input  logic      dn_ready,
  output logic      up_ready,
  output logic      dn_valid,
  output jec_item_t dn_item
);

  logic      valid_r;
  jec_item_t item_r;
  jec_item_t item_nxt;
  logic [K_W-1:0] trial;
  logic           fits;

  // compare against the shifted divisor and subtract where it fits
  always_comb begin
    trial    = {{(K_W-DSH_W){1'b0}}, up_item.dsh};
    fits     = (up_item.rem >= trial);
    item_nxt = up_item;
    item_nxt.rem = fits ? (up_item.rem - trial) : up_item.rem;
    item_nxt.quo = {up_item.quo[MAG_W-2:0], fits};
    item_nxt.dsh = up_item.dsh >> 1;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

// ----- design/joystick_expo_curve_core.sv -----
// top level of the joystick expo curve core: settings, pipeline, output stage
// depends on jec_pkg, jec_front, jec_pow_stage, jec_div_stage and the macros header
//
//  port group | direction | signals
//  -----------+-----------+-----------------------------------------
//  in_        | sink      | in_valid, in_stall, in_stick_value
//  out_       | source    | out_valid, out_stall, out_drive_value
//  cfg_       | sink      | cfg_we, cfg_index, cfg_wdata
//
// one transaction per cycle sustained while the output is not stalled; the path
// from input to output valid runs through the input stage, seven power steps,
// the scaling multiply, seven division steps and the output register
// every stage holds its own valid bit and loads when empty or when its
// successor moves, so bubbles close up and the input stalls only when all
// 17 stages are full and the output is stalled
// synchronous reset clears the valid bits and loads the settings defaults
`include "joystick_expo_curve_core_macros.svh"

module joystick_expo_curve_core import jec_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [STICK_W-1:0] in_stick_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [STICK_W-1:0] out_drive_value,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [RECIP_W-1:0]        cfg_wdata
);

  jec_cfg_t cfg_r;

  logic [POW_STEPS:0] pow_v;
  logic [POW_STEPS:0] pow_rdy;
  jec_item_t          pow_item [POW_STEPS+1];
  logic [DIV_STEPS:0] div_v;
  logic [DIV_STEPS:0] div_rdy;
  jec_item_t          div_item [DIV_STEPS+1];

  logic               front_rdy;
  logic               scale_valid_r;
  jec_item_t          scale_item_r;
  jec_item_t          scale_nxt;
  logic [30:0]        num;
  logic [31:0]        rnd;

  logic               out_valid_r;
  logic [STICK_W-1:0] drive_r;
  logic [STICK_W-1:0] drive_nxt;
  logic [STICK_W-1:0] sum;
  logic [STICK_W-1:0] mag;
  logic [STICK_W-1:0] mag_sat;
  logic               out_rdy;

  // settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_recip <= RECIP_ONE;
      cfg_r.full_scale <= MAG_W'(127);
      cfg_r.deadband   <= '0;
      cfg_r.min_output <= '0;
    end else if (cfg_we) begin
      unique case (jec_reg_t'(cfg_index))
        REG_BASE_RECIP: cfg_r.base_recip <= cfg_wdata;
        REG_FULL_SCALE: cfg_r.full_scale <= cfg_wdata[MAG_W-1:0];
        REG_DEADBAND:   cfg_r.deadband   <= cfg_wdata[MAG_W-1:0];
        REG_MIN_OUTPUT: cfg_r.min_output <= cfg_wdata[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  jec_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_valid),
    .stick_value (in_stick_value),
    .cfg         (cfg_r),
    .dn_ready    (pow_rdy[0]),
    .up_ready    (front_rdy),
    .dn_valid    (pow_v[0]),
    .dn_item     (pow_item[0])
  );

  assign in_stall = !front_rdy;

  // power chain, one exponent bit per stage
  for (genvar g = 0; g < POW_STEPS; g++) begin : g_pow
    jec_pow_stage u_pow (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (pow_v[g]),
      .up_item  (pow_item[g]),
      .dn_ready (pow_rdy[g+1]),
      .up_ready (pow_rdy[g]),
      .dn_valid (pow_v[g+1]),
      .dn_item  (pow_item[g+1])
    );
  end

  // scaling stage: span product times power, plus half the divisor, in q.16
  always_comb begin
    num = {{(31-K_W){1'b0}}, pow_item[POW_STEPS].k}
        * {{(31-RECIP_W){1'b0}}, pow_item[POW_STEPS].acc};
    rnd = {1'b0, num} + {10'd0, pow_item[POW_STEPS].den, 15'd0};
    scale_nxt     = pow_item[POW_STEPS];
    scale_nxt.rem = rnd[K_W+15:16];
    scale_nxt.dsh = {pow_item[POW_STEPS].den, 6'd0};
    scale_nxt.quo = '0;
  end

  assign pow_rdy[POW_STEPS] = !scale_valid_r || div_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_valid_r <= 1'b0;
    end else if (pow_rdy[POW_STEPS]) begin
      scale_valid_r <= pow_v[POW_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (pow_rdy[POW_STEPS] && pow_v[POW_STEPS]) begin
      scale_item_r <= scale_nxt;
    end
  end

  assign div_v[0]    = scale_valid_r;
  assign div_item[0] = scale_item_r;

  // division chain, one quotient bit per stage
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    jec_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (div_v[g]),
      .up_item  (div_item[g]),
      .dn_ready (div_rdy[g+1]),
      .up_ready (div_rdy[g]),
      .dn_valid (div_v[g+1]),
      .dn_item  (div_item[g+1])
    );
  end

  // output stage: offset, special cases, saturation and sign
  always_comb begin
    sum = {1'b0, div_item[DIV_STEPS].quo} + {1'b0, div_item[DIV_STEPS].n};
    if (div_item[DIV_STEPS].zero) begin
      mag = '0;
    end else if (div_item[DIV_STEPS].flat) begin
      mag = {1'b0, div_item[DIV_STEPS].n};
    end else begin
      mag = sum;
    end
    mag_sat   = (mag > STICK_MAX) ? STICK_MAX : mag;
    drive_nxt = div_item[DIV_STEPS].neg ? (STICK_W'(0) - mag_sat) : mag_sat;
  end

  assign out_rdy            = !out_valid_r || !out_stall;
  assign div_rdy[DIV_STEPS] = out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= div_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && div_v[DIV_STEPS]) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_value = $signed(drive_r);

  // input stalls only with every stage occupied
  `JEC_ASSERT_IMP(a_stall_only_full, clk, rst_n, in_stall, &{pow_v, div_v, out_valid_r})
  // a free output side never stalls the input
  `JEC_ASSERT_IMP(a_no_stall_when_drained, clk, rst_n, !out_stall, !in_stall)
  // the magnitude never exceeds the output bound
  `JEC_ASSERT_IMP(a_out_in_range, clk, rst_n, out_valid, out_drive_value != 8'sh80)

endmodule
